>>> hdl/sha1bsh_pkg.sv
// types, constants and helpers shared by the sha-1 byte stream hasher
`timescale 1ns / 1ps

package sha1bsh_pkg;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_ROUND,
      ST_FINISH,
      ST_PAD_MARK,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_OUT
   } st_type;

   // commands from the sequencer to the compression core
   typedef struct packed {
      logic       load_byte;
      logic [7:0] byte_val;
      logic       start;
      logic       round;
      logic [6:0] rnd;
      logic       finish;
      logic       init_h;
      logic [2:0] word_sel;
   } core_cmd_type;

   localparam logic [4:0][31:0] H_INIT = {
      32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };

   localparam logic [3:0][31:0] K_TABLE = {
      32'hCA62C1D6, 32'h8F1BBCDC, 32'h6ED9EBA1, 32'h5A827999
   };

   // round groups
   localparam logic [1:0] RG_CHOOSE  = 2'd0;
   localparam logic [1:0] RG_PARITY1 = 2'd1;
   localparam logic [1:0] RG_MAJOR   = 2'd2;
   localparam logic [1:0] RG_PARITY2 = 2'd3;

   localparam logic [6:0] LAST_ROUND     = 7'd79;
   localparam logic [5:0] FILL_LAST      = 6'd63;
   localparam logic [5:0] FILL_LEN_START = 6'd56;
   localparam logic [2:0] LEN_LAST       = 3'd7;
   localparam logic [2:0] LAST_WORD_IDX  = 3'd4;
   localparam logic [7:0] PAD_MARK_BYTE  = 8'h80;

   function automatic logic [1:0] round_group(input logic [6:0] rnd);
      logic [1:0] grp;
      if (rnd < 7'd20) begin
         grp = RG_CHOOSE;
      end else if (rnd < 7'd40) begin
         grp = RG_PARITY1;
      end else if (rnd < 7'd60) begin
         grp = RG_MAJOR;
      end else begin
         grp = RG_PARITY2;
      end
      return grp;
   endfunction

endpackage

>>> hdl/sha1bsh_core.sv
// sha-1 compression core: block shift line, one round unit, chaining words
`timescale 1ns / 1ps

module sha1bsh_core import sha1bsh_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  core_cmd_type cmd,
   output logic [31:0]  word_out
);

   logic [4:0][31:0] h_ff, h_in;
   logic [31:0]      a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]      a_in, b_in, c_in, d_in, e_in;
   logic [511:0]     blk_ff, blk_in;
   logic [31:0]      w0, w2, w8, w13, w_new;
   logic [31:0]      f_val, k_val, t_val;
   logic [1:0]       grp;

   // schedule taps, w[k] sits at the k-th word from the top
   assign w0    = blk_ff[511:480];
   assign w2    = blk_ff[447:416];
   assign w8    = blk_ff[255:224];
   assign w13   = blk_ff[95:64];
   assign w_new = {w13[30:0] ^ w8[30:0] ^ w2[30:0] ^ w0[30:0],
                   w13[31] ^ w8[31] ^ w2[31] ^ w0[31]};

   assign grp   = round_group(cmd.rnd);
   assign k_val = K_TABLE[grp];

   always_comb begin
      case (grp)
         RG_CHOOSE: f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         RG_MAJOR:  f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         default:   f_val = b_ff ^ c_ff ^ d_ff;
      endcase
   end

   assign t_val = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + w0 + k_val;

   always_comb begin
      h_in   = h_ff;
      a_in   = a_ff;
      b_in   = b_ff;
      c_in   = c_ff;
      d_in   = d_ff;
      e_in   = e_ff;
      blk_in = blk_ff;
      if (cmd.load_byte) begin
         blk_in = {blk_ff[503:0], cmd.byte_val};
      end
      if (cmd.start) begin
         a_in = h_ff[0];
         b_in = h_ff[1];
         c_in = h_ff[2];
         d_in = h_ff[3];
         e_in = h_ff[4];
      end
      if (cmd.round) begin
         a_in   = t_val;
         b_in   = a_ff;
         c_in   = {b_ff[1:0], b_ff[31:2]};
         d_in   = c_ff;
         e_in   = d_ff;
         blk_in = {blk_ff[479:0], w_new};
      end
      if (cmd.finish) begin
         h_in[0] = h_ff[0] + a_ff;
         h_in[1] = h_ff[1] + b_ff;
         h_in[2] = h_ff[2] + c_ff;
         h_in[3] = h_ff[3] + d_ff;
         h_in[4] = h_ff[4] + e_ff;
      end
      if (cmd.init_h) begin
         h_in = H_INIT;
      end
   end

   always_comb begin
      case (cmd.word_sel)
         3'd0:    word_out = h_ff[0];
         3'd1:    word_out = h_ff[1];
         3'd2:    word_out = h_ff[2];
         3'd3:    word_out = h_ff[3];
         3'd4:    word_out = h_ff[4];
         default: word_out = h_ff[0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff <= H_INIT;
      end else begin
         h_ff <= h_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      e_ff   <= e_in;
      blk_ff <= blk_in;
   end

endmodule

>>> hdl/sha1_byte_stream_hasher.sv
// sha-1 byte stream hasher top level: sequencer, counters and handshakes
`timescale 1ns / 1ps

//  channel | direction | payload                                         | handshake
//  req     | in        | data_byte[8], byte_valid, end_of_message        | req_valid/req_ready
//  rsp     | out       | digest_word[32], word_index[3], too_long, last  | rsp_valid/rsp_ready
//
//  an idle transaction (byte or no byte, no end mark) is accepted directly in the idle state
//  every 64th byte starts a compression: load working words, 80 rounds, chaining add
//  end of message: padding is fed one byte per cycle outside compressions (up to 72
//  bytes, and a pause to turn to the length) through one or two compressions, then five
//  digest transactions, one per rsp_ready
//  synchronous active-high reset; no clearing pass, ready the cycle after reset
//  req_ready is low whenever a block is compressing, padding or the digest is out

module sha1_byte_stream_hasher import sha1bsh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_message_too_long,
   output logic        rsp_last_word
);

   st_type       state_ff, state_in;
   st_type       ret_ff, ret_in;      // where to go after a compression
   logic [5:0]   fill_ff, fill_in;    // bytes held in the current block
   logic [63:0]  bit_count_ff, bit_count_in;
   logic         ovf_ff, ovf_in;      // sticky length overflow
   logic [6:0]   rnd_ff, rnd_in;
   logic [2:0]   lcnt_ff, lcnt_in;    // length byte counter
   logic [2:0]   oidx_ff, oidx_in;    // digest word counter
   logic [64:0]  count_sum;
   logic         absorb;
   core_cmd_type cmd;
   logic [31:0]  core_word;

   sha1bsh_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .word_out (core_word)
   );

   assign count_sum = {1'b0, bit_count_ff} + 65'd8;
   // a byte is taken into the block only before the length has overflowed
   assign absorb    = req_byte_valid && !ovf_ff;

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      fill_in      = fill_ff;
      bit_count_in = bit_count_ff;
      ovf_in       = ovf_ff;
      rnd_in       = rnd_ff;
      lcnt_in      = lcnt_ff;
      oidx_in      = oidx_ff;
      cmd          = '0;
      cmd.word_sel = oidx_ff;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ret_in = req_end_of_message ? ST_PAD_MARK : ST_IDLE;
               if (absorb) begin
                  cmd.load_byte = 1'b1;
                  cmd.byte_val  = req_data_byte;
                  fill_in       = fill_ff + 6'd1;
                  bit_count_in  = count_sum[63:0];
                  if (count_sum[64]) begin
                     ovf_in = 1'b1;
                  end
               end
               if (absorb && fill_ff == FILL_LAST) begin
                  state_in = ST_START;
               end else if (req_end_of_message) begin
                  state_in = ST_PAD_MARK;
               end
            end
         end
         ST_START: begin
            cmd.start = 1'b1;
            rnd_in    = '0;
            state_in  = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            cmd.rnd   = rnd_ff;
            rnd_in    = rnd_ff + 7'd1;
            if (rnd_ff == LAST_ROUND) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ret_ff;
         end
         ST_PAD_MARK: begin
            cmd.load_byte = 1'b1;
            cmd.byte_val  = PAD_MARK_BYTE;
            fill_in       = fill_ff + 6'd1;
            state_in      = ST_PAD_ZERO;
            if (fill_ff == FILL_LAST) begin
               ret_in   = ST_PAD_ZERO;
               state_in = ST_START;
            end
         end
         ST_PAD_ZERO: begin
            if (fill_ff == FILL_LEN_START) begin
               lcnt_in  = '0;
               state_in = ST_PAD_LEN;
            end else begin
               cmd.load_byte = 1'b1;
               fill_in       = fill_ff + 6'd1;
               if (fill_ff == FILL_LAST) begin
                  ret_in   = ST_PAD_ZERO;
                  state_in = ST_START;
               end
            end
         end
         ST_PAD_LEN: begin
            // big-endian length, count shifted out a byte at a time
            cmd.load_byte = 1'b1;
            cmd.byte_val  = bit_count_ff[63:56];
            bit_count_in  = {bit_count_ff[55:0], 8'h00};
            fill_in       = fill_ff + 6'd1;
            lcnt_in       = lcnt_ff + 3'd1;
            if (lcnt_ff == LEN_LAST) begin
               oidx_in  = '0;
               ret_in   = ST_OUT;
               state_in = ST_START;
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (oidx_ff == LAST_WORD_IDX) begin
                  // back to the initial state for the next message
                  cmd.init_h   = 1'b1;
                  bit_count_in = '0;
                  ovf_in       = 1'b0;
                  fill_in      = '0;
                  oidx_in      = '0;
                  state_in     = ST_IDLE;
               end else begin
                  oidx_in = oidx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_digest_word      = core_word;
   assign rsp_word_index       = oidx_ff;
   assign rsp_message_too_long = ovf_ff;
   assign rsp_last_word        = (oidx_ff == LAST_WORD_IDX);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         fill_ff      <= '0;
         bit_count_ff <= '0;
         ovf_ff       <= 1'b0;
         rnd_ff       <= '0;
         lcnt_ff      <= '0;
         oidx_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         fill_ff      <= fill_in;
         bit_count_ff <= bit_count_in;
         ovf_ff       <= ovf_in;
         rnd_ff       <= rnd_in;
         lcnt_ff      <= lcnt_in;
         oidx_ff      <= oidx_in;
      end
   end

   // a full block always starts a compression
   a_full_block: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && absorb && fill_ff == FILL_LAST)
      |=> state_ff == ST_START)
      else $error("full block did not start compression");

   // length bytes land in the last eight byte slots of the block
   a_len_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PAD_LEN |-> fill_ff == {FILL_LEN_START[5:3], lcnt_ff})
      else $error("length byte out of place");

   // the round counter never runs past the last round
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND |-> rnd_ff <= LAST_ROUND)
      else $error("round counter out of range");

   // last digest transaction returns the block to idle
   a_last_word_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_word) |=> (!rsp_valid && req_ready))
      else $error("no return to idle after digest");

   // digest index stays within five words
   a_word_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word_index <= LAST_WORD_IDX)
      else $error("digest word index out of range");

endmodule

>>> test/sha1_byte_stream_hasher_tb.sv
// self-checking testbench for the sha-1 byte stream hasher with its own digest predictor
`timescale 1ns / 1ps

module sha1_byte_stream_hasher_tb;
   import sha1bsh_pkg::*;

   localparam int CLOCK_HALF     = 5;
   localparam int RESET_CYCLES   = 4;
   localparam int PHASE_ITEMS    = 90;     // at least this many byte or end-mark transactions per idling phase
   localparam int HOLD_CYCLES    = 400;    // long receiver hold-off in the pressure phase
   localparam int DRAIN_CYCLES   = 300;    // two compressions plus padding, with margin
   localparam int CYCLE_LIMIT    = 1000000;
   localparam int MAX_REPORTS    = 10;
   localparam int DIGEST_WORDS   = 5;

   // idling patterns, one per random phase
   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   // one request transaction as queued for the driver
   typedef struct {
      logic [7:0] data;
      logic       valid;
      logic       eom;
   } hash_req_type;

   // one expected digest transaction
   typedef struct {
      logic [31:0] word;
      logic [2:0]  index;
      logic        too_long;
      logic        last;
   } digest_result_type;

   // dut ports, inputs known from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_byte_valid = 1'b0;
   logic        req_end_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_message_too_long;
   logic        rsp_last_word;

   // stimulus bookkeeping
   hash_req_type      pending_reqs[$];
   digest_result_type digest_expect[$];
   int                queued_count = 0;
   int                accepted_count = 0;
   int                counted_items = 0;     // transactions carrying a byte or an end mark
   int                error_count = 0;
   int                cycle_count = 0;
   int                sender_idle_pct = 0;
   int                receiver_stall_pct = 0;

   // long hold-off of the receiver
   logic           hold_armed = 1'b0;
   logic           rsp_hold = 1'b0;
   int             hold_count = 0;

   // predictor state: chaining words, block bytes, fill, bit length, overflow flag
   logic [31:0]    chain_words[DIGEST_WORDS];
   logic [7:0]     blk_bytes[64];
   int             blk_fill;
   logic [63:0]    bit_total;
   logic           len_overflow;

   sha1_byte_stream_hasher u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_byte        (req_data_byte),
      .req_byte_valid       (req_byte_valid),
      .req_end_of_message   (req_end_of_message),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_digest_word      (rsp_digest_word),
      .rsp_word_index       (rsp_word_index),
      .rsp_message_too_long (rsp_message_too_long),
      .rsp_last_word        (rsp_last_word)
   );

   always #(CLOCK_HALF) clock = ~clock;

   // ---------------------------------------------------------------------------
   // digest predictor
   // ---------------------------------------------------------------------------

   function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   // back to the initial hash values and an empty message
   function automatic void sha1_restart();
      for (int k = 0; k < DIGEST_WORDS; k++) begin
         chain_words[k] = H_INIT[k];
      end
      blk_fill     = 0;
      bit_total    = 64'd0;
      len_overflow = 1'b0;
   endfunction

   // 80 rounds over the 64 block bytes, folded into the chaining words
   function automatic void sha1_compress();
      logic [31:0] w[80];
      logic [31:0] a, b, c, d, e, f, t, k;
      for (int i = 0; i < 16; i++) begin
         w[i] = {blk_bytes[4 * i], blk_bytes[4 * i + 1], blk_bytes[4 * i + 2],
                 blk_bytes[4 * i + 3]};
      end
      for (int i = 16; i < 80; i++) begin
         w[i] = rotl(w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16], 1);
      end
      a = chain_words[0];
      b = chain_words[1];
      c = chain_words[2];
      d = chain_words[3];
      e = chain_words[4];
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d);
         end else if (i < 40 || i >= 60) begin
            f = b ^ c ^ d;
         end else begin
            f = (b & c) | (b & d) | (c & d);
         end
         k = K_TABLE[i / 20];
         t = rotl(a, 5) + f + e + w[i] + k;
         e = d;
         d = c;
         c = rotl(b, 30);
         b = a;
         a = t;
      end
      chain_words[0] += a;
      chain_words[1] += b;
      chain_words[2] += c;
      chain_words[3] += d;
      chain_words[4] += e;
      blk_fill = 0;
   endfunction

   // marker byte, zeros and the big-endian bit length; a second block when it will not fit
   function automatic void sha1_pad();
      int pos;
      blk_bytes[blk_fill] = PAD_MARK_BYTE;
      pos = blk_fill + 1;
      if (pos > FILL_LEN_START) begin
         while (pos < 64) begin
            blk_bytes[pos] = 8'h00;
            pos++;
         end
         sha1_compress();
         pos = 0;
      end
      while (pos < FILL_LEN_START) begin
         blk_bytes[pos] = 8'h00;
         pos++;
      end
      for (int i = 0; i < 8; i++) begin
         blk_bytes[FILL_LEN_START + i] = bit_total[63 - 8 * i -: 8];
      end
      sha1_compress();
   endfunction

   // one accepted request: absorb its byte, and on an end mark queue the five digest words
   function automatic void sha1_absorb(input hash_req_type it);
      digest_result_type r;
      if (it.valid && !len_overflow) begin
         blk_bytes[blk_fill] = it.data;
         blk_fill++;
         bit_total += 64'd8;
         if (bit_total == 64'd0) begin
            len_overflow = 1'b1;
         end
         if (blk_fill == 64) begin
            sha1_compress();
         end
      end
      if (it.eom) begin
         sha1_pad();
         for (int k = 0; k < DIGEST_WORDS; k++) begin
            r.word     = chain_words[k];
            r.index    = 3'(k);
            r.too_long = len_overflow;
            r.last     = (3'(k) == LAST_WORD_IDX);
            digest_expect.push_back(r);
         end
         sha1_restart();
      end
   endfunction

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------

   function automatic void queue_req(input logic [7:0] data, input logic valid,
                                     input logic eom);
      hash_req_type it;
      it.data  = data;
      it.valid = valid;
      it.eom   = eom;
      pending_reqs.push_back(it);
      queued_count++;
      if (valid || eom) begin
         counted_items++;
      end
   endfunction

   // one message of len bytes with random content, some ignored transactions mixed in;
   // the end mark rides on the last byte or on a transaction of its own
   function automatic void queue_message(input int len);
      logic separate_end;
      separate_end = (len == 0) || ($urandom_range(1) == 1);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < 8) begin
            queue_req(8'($urandom), 1'b0, 1'b0);
         end
         queue_req(8'($urandom), 1'b1, !separate_end && (i == len - 1));
      end
      if (separate_end) begin
         queue_req(8'($urandom), 1'b0, 1'b1);
      end
   endfunction

   // lengths lean on the padding edges: 55 fits the length, 56 does not, 64 fills a block
   function automatic int pick_length();
      int edges[8] = '{55, 56, 57, 63, 64, 65, 119, 120};
      int sel;
      sel = $urandom_range(9);
      if (sel < 4) begin
         return $urandom_range(8);
      end else if (sel < 7) begin
         return edges[$urandom_range(7)];
      end
      return $urandom_range(70);
   endfunction

   // all queued transactions accepted and every digest word returned
   task automatic wait_drained();
      while (accepted_count != queued_count || digest_expect.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // ---------------------------------------------------------------------------
   // request driver: offers queued transactions, predicts on acceptance
   // ---------------------------------------------------------------------------

   always @(posedge clock) begin
      hash_req_type taken;
      hash_req_type nxt;
      logic         holding;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         holding = req_valid;
         if (req_valid && req_ready) begin
            taken.data  = req_data_byte;
            taken.valid = req_byte_valid;
            taken.eom   = req_end_of_message;
            // expectations first, then the count the main sequence watches
            sha1_absorb(taken);
            accepted_count++;
            holding = 1'b0;
         end
         if (!holding) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               nxt = pending_reqs.pop_front();
               req_valid          <= 1'b1;
               req_data_byte      <= nxt.data;
               req_byte_valid     <= nxt.valid;
               req_end_of_message <= nxt.eom;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // receiver: random stalls, plus the long hold-off when armed
   // ---------------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_hold   <= 1'b0;
         hold_count <= 0;
      end else if (hold_armed && hold_count < HOLD_CYCLES) begin
         rsp_hold   <= 1'b1;
         hold_count <= hold_count + 1;
      end else begin
         rsp_hold <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !rsp_hold && ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // ---------------------------------------------------------------------------
   // digest monitor: each returned word against the oldest expectation
   // ---------------------------------------------------------------------------

   always @(posedge clock) begin
      digest_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (digest_expect.size() == 0) begin
            if (error_count < MAX_REPORTS) begin
               $display("unexpected digest: word %08h index %0d too_long %0b last %0b",
                        rsp_digest_word, rsp_word_index, rsp_message_too_long, rsp_last_word);
            end
            error_count++;
         end else begin
            want = digest_expect.pop_front();
            if (rsp_digest_word !== want.word || rsp_word_index !== want.index ||
                rsp_message_too_long !== want.too_long || rsp_last_word !== want.last) begin
               if (error_count < MAX_REPORTS) begin
                  $display("mismatch at %0t: expected word %08h index %0d too_long %0b last %0b",
                           $realtime, want.word, want.index, want.too_long, want.last);
                  $display("               actual   word %08h index %0d too_long %0b last %0b",
                           rsp_digest_word, rsp_word_index, rsp_message_too_long,
                           rsp_last_word);
               end
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sha1_byte_stream_hasher_tb failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------

   initial begin
      sha1_restart();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: empty message, "abc" with the end mark on its last byte,
      // ignored transactions with all-ones and all-zero data, extreme bytes,
      // and an end mark carried by a transaction without a byte
      queue_req(8'hFF, 1'b0, 1'b1);
      queue_req(8'h61, 1'b1, 1'b0);
      queue_req(8'h62, 1'b1, 1'b0);
      queue_req(8'h63, 1'b1, 1'b1);
      queue_req(8'hFF, 1'b0, 1'b0);
      queue_req(8'h00, 1'b0, 1'b0);
      queue_req(8'h00, 1'b1, 1'b0);
      queue_req(8'hFF, 1'b1, 1'b0);
      queue_req(8'hA5, 1'b0, 1'b0);
      queue_req(8'h5A, 1'b0, 1'b1);
      queue_req(8'h00, 1'b1, 1'b1);
      queue_req(8'hFF, 1'b1, 1'b1);
      queue_req(8'h00, 1'b0, 1'b1);
      wait_drained();

      // random messages under each idling pattern
      for (int m = IDLE_NONE; m <= IDLE_BOTH; m++) begin
         case (idle_mode_type'(m))
            IDLE_NONE: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            IDLE_SENDER: begin
               sender_idle_pct    = 81;
               receiver_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 81;
            end
            default: begin
               sender_idle_pct    = 35;
               receiver_stall_pct = 35;
            end
         endcase
         counted_items = 0;
         while (counted_items < PHASE_ITEMS) begin
            queue_message(pick_length());
         end
         wait_drained();
      end

      // back-pressure: receiver held off while short messages keep coming,
      // so digests back up and the request side stalls
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_armed         = 1'b1;
      for (int n = 0; n < 8; n++) begin
         queue_message($urandom_range(6));
      end
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && digest_expect.size() == 0) begin
         $display("sha1_byte_stream_hasher_tb passed");
      end else begin
         $display("sha1_byte_stream_hasher_tb failed");
      end
      $finish;
   end

endmodule
